// ----- hw/rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the cells and the top level of the priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] pages;
    logic [7:0]  prio;
  } job_rec_t;

  typedef enum logic [1:0] {
    StatusDone  = 2'd0,
    StatusEmpty = 2'd1,
    StatusFull  = 2'd2
  } status_e;

  typedef enum logic {
    ActPush = 1'b0,
    ActPop  = 1'b1
  } action_e;

  typedef struct packed {
    logic     push;
    logic     pop;
    job_rec_t rec;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/stable_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// stable_priority_queue_core
// Latency: the result of an item appears in the cycle after it is accepted.
// Throughput: one item per cycle; busy stays low, set by the row of cells
// that compares and shifts all slots at once.
// Reset clears the fill count and the result strobe; slot contents are left
// as they are and are only read below the fill count. Results cannot stall.
// ----------------------------------------------------------------------------
module stable_priority_queue_core #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        action_i,
  input  logic [15:0] job_id_i,
  input  logic [15:0] page_count_i,
  input  logic [7:0]  job_priority_i,
  output logic        done_o,
  output logic [15:0] out_id_o,
  output logic [15:0] out_pages_o,
  output logic [7:0]  out_priority_o,
  output logic [1:0]  status_o,
  output logic [4:0]  entry_count_o
);
  import spq_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            done_q;
  job_rec_t        res_rec_q, res_rec_d;
  status_e         res_status_q, res_status_d;
  cell_ctrl_t      ctrl;
  logic            is_full, is_empty, take;
  job_rec_t        recs  [QUEUE_DEPTH];
  logic            stays [QUEUE_DEPTH];

  assign busy     = 1'b0;
  assign take     = start && !busy;
  assign is_full  = count_q == CntW'(QUEUE_DEPTH);
  assign is_empty = count_q == '0;

  assign ctrl.rec.id    = job_id_i;
  assign ctrl.rec.pages = page_count_i;
  assign ctrl.rec.prio  = job_priority_i;
  assign ctrl.push      = take && (action_i == ActPush) && !is_full;
  assign ctrl.pop       = take && (action_i == ActPop) && !is_empty;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    spq_cell #(
      .CNT_W(CntW),
      .IDX  (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .prev_stay_i((i == 0) ? 1'b1 : stays[(i == 0) ? 0 : i - 1]),
      .prev_rec_i ((i == 0) ? ctrl.rec : recs[(i == 0) ? 0 : i - 1]),
      .next_rec_i ((i == QUEUE_DEPTH - 1) ? recs[i] : recs[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .rec_o      (recs[i]),
      .stay_o     (stays[i])
    );
  end

  always_comb begin
    count_d      = count_q;
    res_rec_d    = '0;
    res_status_d = StatusDone;
    if (ctrl.push) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.pop) begin
      count_d   = count_q - CntW'(1);
      res_rec_d = recs[0];
    end else if (take && (action_i == ActPush)) begin
      res_status_d = StatusFull;
    end else if (take) begin
      res_status_d = StatusEmpty;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_rec_q    <= res_rec_d;
      res_status_q <= res_status_d;
    end
  end

  assign done_o         = done_q;
  assign out_id_o       = res_rec_q.id;
  assign out_pages_o    = res_rec_q.pages;
  assign out_priority_o = res_rec_q.prio;
  assign status_o       = res_status_q;
  assign entry_count_o  = 5'(count_q);

  a_count_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("fill count above depth");

  a_done_follows_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> done_o)
    else $error("accepted item without result strobe");

  a_full_drop : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && action_i == ActPush && is_full) |=> (status_o == StatusFull && $stable(count_q)))
    else $error("push on full queue not dropped");

  a_pop_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && action_i == ActPop && is_empty) |=> (status_o == StatusEmpty && count_q == '0))
    else $error("pop on empty queue mishandled");

endmodule

// ----- hw/rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: keeps its record, takes the new record, takes
// its lower neighbor's record on an insert, or its upper neighbor's on a pop.
// ----------------------------------------------------------------------------
module spq_cell #(
  parameter int CNT_W = 5,
  parameter int IDX   = 0
) (
  input  logic                clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  logic [CNT_W-1:0]    count_i,
  input  logic                prev_stay_i,
  input  spq_pkg::job_rec_t   prev_rec_i,
  input  spq_pkg::job_rec_t   next_rec_i,
  output spq_pkg::job_rec_t   rec_o,
  output logic                stay_o
);
  import spq_pkg::*;

  job_rec_t rec_q, rec_d;
  logic     occupied;

  assign occupied = count_i > CNT_W'(IDX);
  assign stay_o   = occupied && (rec_q.prio <= ctrl_i.rec.prio);
  assign rec_o    = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.push) begin
      if (stay_o) begin
        rec_d = rec_q;
      end else if (prev_stay_i) begin
        rec_d = ctrl_i.rec;
      end else begin
        rec_d = prev_rec_i;
      end
    end else if (ctrl_i.pop) begin
      rec_d = next_rec_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

endmodule
